// ----- rtl/ssh_pkg.sv -----
// swept sphere hit: shared widths, constants and pipeline payload types
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package ssh_pkg;
	localparam int CW   = 32;            // coordinate bits
	localparam int FW   = 16;            // fraction bits
	localparam int RW   = 31;            // radius bits
	localparam int NF   = 14;            // normal fraction bits
	localparam int TW   = FW + 1;        // impact time bits
	localparam int VW   = CW + 1;        // difference vector bits
	localparam int QW   = 2 * VW + 2;    // a, h, c bits
	localparam int PH   = QW / 2;        // partial product split
	localparam int DW   = 2 * QW + 4;    // discriminant bits
	localparam int ATW  = QW + TW + 3;   // a*t and h*2^fw bits
	localparam int GW   = QW + 2 * FW + 12; // scaled quadratic bits
	localparam int EW   = VW + 1;        // displacement bits
	localparam int PW   = VW + TW + 1;   // displacement product bits
	localparam int SSW  = 2 * EW + 2;    // squared travel bits
	localparam int TRW  = 32;            // travel distance bits
	localparam int SQW  = 2 * TRW + 2;   // travel square bits
	localparam int NQW  = QW + NF + 2;   // n*qq bits
	localparam int NSW  = QW + 2 * NF + 4; // n^2*qq bits
	localparam int NW   = 16;            // normal output bits
	localparam int TSTEPS = FW + 1;      // impact time search stages
	localparam int RSTEPS = TRW;         // square root stages
	localparam int T_FULL = 1 << FW;
	localparam int N_ONE  = 1 << NF;
	localparam logic [CW-1:0] STEP_RESET = CW'(T_FULL);

	typedef struct packed {
		logic [2:0][CW-1:0] st;
		logic [2:0][VW-1:0] d;
		logic [2:0][CW-1:0] cen;
	} geom_t;

	typedef struct packed {
		logic          hit;
		logic          first;
		logic [QW-1:0] a;
		logic [QW-1:0] h;
		logic [QW-1:0] c;
		geom_t         geo;
	} front_t;

	typedef struct packed {
		logic           hit;
		logic           first;
		logic [QW-1:0]  a;
		logic [ATW-1:0] hs;
		logic [ATW-1:0] at;
		logic [GW-1:0]  gq;
		logic [TW-1:0]  t;
		geom_t          geo;
	} tstep_t;

	typedef struct packed {
		logic          hit;
		logic [TW-1:0] t;
		geom_t         geo;
	} tres_t;

	typedef struct packed {
		logic                 hit;
		logic [TW-1:0]        t;
		logic [2:0][CW-1:0]   con;
		logic [2:0]           neg;
		logic [2:0][2*VW-1:0] m2;
		logic [QW-1:0]        qq;
		logic [SSW-1:0]       ss;
	} cres_t;

	typedef struct packed {
		logic                hit;
		logic [TW-1:0]       t;
		logic [2:0][CW-1:0]  con;
		logic [2:0]          neg;
		logic                nz;
		logic                sat;
		logic [2:0][NF:0]    n;
		logic [2:0][NQW-1:0] nq;
		logic [2:0][NSW-1:0] nsq;
		logic [2:0][NSW-1:0] tgt;
		logic [QW-1:0]       qq;
		logic [2*TRW-1:0]    ss;
		logic [TRW-1:0]      trav;
		logic [SQW-1:0]      sq;
	} rstep_t;
endpackage
`default_nettype wire

// ----- rtl/ssh_front.sv -----
// swept sphere hit: quadratic set-up, discriminant and root choice (five stages)
// depends on ssh_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssh_front import ssh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [RW-1:0]      mr,
	input  wire logic [RW-1:0]      sr,
	input  wire logic [2:0][CW-1:0] cen,
	input  wire logic [2:0][CW-1:0] st,
	input  wire logic [2:0][CW-1:0] fin,
	output logic                    out_valid,
	output front_t                  out_data
);
	logic [5:1] vld_s;
	geom_t geo_s1, geo_s2, geo_s3, geo_s4;
	logic signed [VW-1:0] p_s1 [3];
	logic [CW-1:0] rad_s1;
	logic signed [2*VW-1:0] dd_s2 [3];
	logic signed [2*VW-1:0] dp_s2 [3];
	logic signed [2*VW-1:0] pp_s2 [3];
	logic [2*CW-1:0] rr_s2;
	logic signed [QW-1:0] a_s3, h_s3, c_s3;
	logic signed [QW-1:0] a_s4, h_s4, c_s4;
	logic signed [QW+1:0] fone_s4;
	logic signed [QW:0] apl_s4;
	logic signed [2*PH-1:0] hh2_s4, ach_s4;
	logic signed [2*PH:0] hm_s4, acm1_s4, acm2_s4;
	logic [2*PH-1:0] hl2_s4, acl_s4;
	logic signed [DW-1:0] dis;
	logic h_le, c_ge, c_le, apl_ge, fone_le, fone_ge, s0, s1;
	front_t res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: motion and offset vectors
			for (int i = 0; i < 3; i++) begin
				geo_s1.st[i]  <= st[i];
				geo_s1.cen[i] <= cen[i];
				geo_s1.d[i]   <= $signed({fin[i][CW-1], fin[i]}) - $signed({st[i][CW-1], st[i]});
				p_s1[i]       <= $signed({st[i][CW-1], st[i]}) - $signed({cen[i][CW-1], cen[i]});
			end
			rad_s1 <= {1'b0, mr} + {1'b0, sr};
			// stage 2: products
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= $signed(geo_s1.d[i]) * $signed(geo_s1.d[i]);
				dp_s2[i] <= $signed(geo_s1.d[i]) * p_s1[i];
				pp_s2[i] <= p_s1[i] * p_s1[i];
			end
			rr_s2  <= rad_s1 * rad_s1;
			geo_s2 <= geo_s1;
			// stage 3: quadratic coefficients
			a_s3 <= QW'(dd_s2[0]) + QW'(dd_s2[1]) + QW'(dd_s2[2]);
			h_s3 <= QW'(dp_s2[0]) + QW'(dp_s2[1]) + QW'(dp_s2[2]);
			c_s3 <= QW'(pp_s2[0]) + QW'(pp_s2[1]) + QW'(pp_s2[2]) - $signed(QW'(rr_s2));
			geo_s3 <= geo_s2;
			// stage 4: split partial products of h*h and a*c
			hh2_s4  <= $signed(h_s3[QW-1:PH]) * $signed(h_s3[QW-1:PH]);
			hm_s4   <= $signed(h_s3[QW-1:PH]) * $signed({1'b0, h_s3[PH-1:0]});
			hl2_s4  <= h_s3[PH-1:0] * h_s3[PH-1:0];
			ach_s4  <= $signed(a_s3[QW-1:PH]) * $signed(c_s3[QW-1:PH]);
			acm1_s4 <= $signed(a_s3[QW-1:PH]) * $signed({1'b0, c_s3[PH-1:0]});
			acm2_s4 <= $signed({1'b0, a_s3[PH-1:0]}) * $signed(c_s3[QW-1:PH]);
			acl_s4  <= a_s3[PH-1:0] * c_s3[PH-1:0];
			fone_s4 <= (QW+2)'(a_s3) + ((QW+2)'(h_s3) <<< 1) + (QW+2)'(c_s3);
			apl_s4  <= (QW+1)'(a_s3) + (QW+1)'(h_s3);
			a_s4 <= a_s3;
			h_s4 <= h_s3;
			c_s4 <= c_s3;
			geo_s4 <= geo_s3;
			// stage 5: root choice
			res_s5 <= '{hit: (a_s4 != 0) && !dis[DW-1] && (s0 || s1), first: s0,
				a: a_s4, h: h_s4, c: c_s4, geo: geo_s4};
		end
	end

	always_comb begin
		dis = (DW'(hh2_s4) <<< (2*PH)) + (DW'(hm_s4) <<< (PH+1))
			+ DW'($signed({1'b0, hl2_s4})) - (DW'(ach_s4) <<< (2*PH))
			- ((DW'(acm1_s4) + DW'(acm2_s4)) <<< PH) - DW'($signed({1'b0, acl_s4}));
		h_le    = h_s4[QW-1] || (h_s4 == 0);
		c_ge    = !c_s4[QW-1];
		c_le    = c_s4[QW-1] || (c_s4 == 0);
		apl_ge  = !apl_s4[QW];
		fone_le = fone_s4[QW+1] || (fone_s4 == 0);
		fone_ge = !fone_s4[QW+1];
		// entry root when outside, exit root when starting inside
		s0 = h_le && c_ge && (apl_ge || fone_le);
		s1 = (h_le || c_le) && apl_ge && fone_ge;
	end

	assign out_valid = vld_s[5];
	assign out_data  = res_s5;
endmodule
`default_nettype wire

// ----- rtl/ssh_tsearch.sv -----
// swept sphere hit: impact time search, one bit per stage by shift and add
// depends on ssh_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssh_tsearch import ssh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  front_t    in_data,
	output logic      out_valid,
	output tres_t     out_data
);
	tstep_t init;
	tstep_t ts_s [TSTEPS];
	logic [TSTEPS-1:0] vld_s;

	always_comb begin
		init.hit   = in_data.hit;
		init.first = in_data.first;
		init.a     = in_data.a;
		init.hs    = ATW'($signed(in_data.h)) <<< FW;
		init.at    = '0;
		init.gq    = GW'($signed(in_data.c)) <<< (2*FW);
		init.t     = '0;
		init.geo   = in_data.geo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TSTEPS-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < TSTEPS; k++) begin : g_step
		localparam int B = FW - k;
		tstep_t cur, nxt;
		logic signed [ATW-1:0] at_c, lin;
		logic signed [GW-1:0] g_c;
		logic [TW-1:0] cand;
		logic ok;

		if (k == 0) begin : g_head
			assign cur = init;
		end else begin : g_tail
			assign cur = ts_s[k-1];
		end

		// g(t+2^b) = g(t) + 2^(b+1)*(a*t + h*2^fw) + a*2^(2b)
		always_comb begin
			cand = cur.t | (TW'(1) << B);
			at_c = $signed(cur.at) + $signed(ATW'(cur.a) << B);
			lin  = at_c + $signed(cur.hs);
			g_c  = $signed(cur.gq)
				+ ((GW'($signed(cur.at)) + GW'($signed(cur.hs))) <<< (B+1))
				+ $signed(GW'(cur.a) << (2*B));
			ok = (cand <= TW'(T_FULL))
				&& (cur.first ? (lin <= 0 && g_c >= 0) : (g_c <= 0));
			nxt = cur;
			if (ok) begin
				nxt.t  = cand;
				nxt.at = at_c;
				nxt.gq = g_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ts_s[k] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[TSTEPS-1];
	assign out_data  = '{hit: ts_s[TSTEPS-1].hit, t: ts_s[TSTEPS-1].t,
		geo: ts_s[TSTEPS-1].geo};
endmodule
`default_nettype wire

// ----- rtl/ssh_contact.sv -----
// swept sphere hit: contact centre, offset from static centre and squared lengths
// depends on ssh_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssh_contact import ssh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  tres_t     in_data,
	output logic      out_valid,
	output cres_t     out_data
);
	logic [4:1] vld_s;
	logic signed [PW-1:0] prod_s1 [3];
	logic [2:0][CW-1:0] st_s1, cen_s1, con_s2, con_s3;
	logic hit_s1, hit_s2, hit_s3;
	logic [TW-1:0] t_s1, t_s2, t_s3;
	logic signed [EW-1:0] e_s2 [3];
	logic signed [VW-1:0] q_s2 [3];
	logic [2:0][2*VW-1:0] m2_s3;
	logic [2*EW-1:0] e2_s3 [3];
	logic [2:0] neg_s3;
	logic [2:0][CW-1:0] con_c;
	cres_t res_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			con_c[i] = st_s1[i] + prod_s1[i][FW +: CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: d * t
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= $signed(in_data.geo.d[i]) * $signed({1'b0, in_data.t});
			end
			st_s1  <= in_data.geo.st;
			cen_s1 <= in_data.geo.cen;
			hit_s1 <= in_data.hit;
			t_s1   <= in_data.t;
			// stage 2: floor of d*t, contact and offset
			for (int i = 0; i < 3; i++) begin
				e_s2[i] <= prod_s1[i][FW +: EW];
				q_s2[i] <= $signed({con_c[i][CW-1], con_c[i]})
					- $signed({cen_s1[i][CW-1], cen_s1[i]});
			end
			con_s2 <= con_c;
			hit_s2 <= hit_s1;
			t_s2   <= t_s1;
			// stage 3: squares
			for (int i = 0; i < 3; i++) begin
				m2_s3[i]  <= q_s2[i] * q_s2[i];
				e2_s3[i]  <= e_s2[i] * e_s2[i];
				neg_s3[i] <= q_s2[i][VW-1];
			end
			con_s3 <= con_s2;
			hit_s3 <= hit_s2;
			t_s3   <= t_s2;
			// stage 4: sums
			res_s4.hit <= hit_s3;
			res_s4.t   <= t_s3;
			res_s4.con <= con_s3;
			res_s4.neg <= neg_s3;
			res_s4.m2  <= m2_s3;
			res_s4.qq  <= QW'(m2_s3[0]) + QW'(m2_s3[1]) + QW'(m2_s3[2]);
			res_s4.ss  <= SSW'(e2_s3[0]) + SSW'(e2_s3[1]) + SSW'(e2_s3[2]);
		end
	end

	assign out_valid = vld_s[4];
	assign out_data  = res_s4;
endmodule
`default_nettype wire

// ----- rtl/ssh_roots.sv -----
// swept sphere hit: normal components and travel length by digit-per-stage roots
// depends on ssh_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssh_roots import ssh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  cres_t     in_data,
	output logic      out_valid,
	output rstep_t    out_data
);
	rstep_t init;
	rstep_t rs_s [RSTEPS];
	logic [RSTEPS-1:0] vld_s;

	always_comb begin
		init.hit  = in_data.hit;
		init.t    = in_data.t;
		init.con  = in_data.con;
		init.neg  = in_data.neg;
		init.nz   = in_data.qq != '0;
		init.sat  = |in_data.ss[SSW-1:2*TRW];
		init.n    = '0;
		init.nq   = '0;
		init.nsq  = '0;
		for (int i = 0; i < 3; i++) begin
			init.tgt[i] = NSW'(in_data.m2[i]) << (2*NF);
		end
		init.qq   = in_data.qq;
		init.ss   = in_data.ss[2*TRW-1:0];
		init.trav = '0;
		init.sq   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RSTEPS-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < RSTEPS; k++) begin : g_step
		localparam int TB   = TRW - 1 - k;
		localparam bit DO_N = (k <= NF);
		localparam int NB   = DO_N ? (NF - k) : 0;
		rstep_t cur, nxt;
		logic [SQW-1:0] sq_c;
		logic [NSW-1:0] nsq_c [3];
		logic [NF:0] ncand [3];

		if (k == 0) begin : g_head
			assign cur = init;
		end else begin : g_tail
			assign cur = rs_s[k-1];
		end

		always_comb begin
			nxt = cur;
			// travel: (r+2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
			sq_c = cur.sq + (SQW'(cur.trav) << (TB+1)) + (SQW'(1) << (2*TB));
			if (sq_c <= SQW'(cur.ss)) begin
				nxt.trav = cur.trav | (TRW'(1) << TB);
				nxt.sq   = sq_c;
			end
			// normal: largest n with n^2*qq <= q^2*2^(2*nf)
			for (int i = 0; i < 3; i++) begin
				ncand[i] = cur.n[i] | ((NF+1)'(1) << NB);
				nsq_c[i] = cur.nsq[i] + (NSW'(cur.nq[i]) << (NB+1))
					+ (NSW'(cur.qq) << (2*NB));
				if (DO_N && ncand[i] <= (NF+1)'(N_ONE) && nsq_c[i] <= cur.tgt[i]) begin
					nxt.n[i]   = ncand[i];
					nxt.nq[i]  = cur.nq[i] + (NQW'(cur.qq) << NB);
					nxt.nsq[i] = nsq_c[i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rs_s[k] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[RSTEPS-1];
	assign out_data  = rs_s[RSTEPS-1];
endmodule
`default_nettype wire

// ----- rtl/swept_sphere_sphere_hit.sv -----
// swept sphere hit: top level, configuration register, stall control, output register
// depends on ssh_pkg, ssh_front, ssh_tsearch, ssh_contact, ssh_roots
`timescale 1ns / 1ps
`default_nettype none
// Continuous collision of a moving sphere against a static sphere over one
// time step, all coordinates signed Q16.16. The moving centre sweeps start to
// end against the static sphere grown by the moving radius; the earliest root
// of the swept quadratic inside the step gives the impact time (Q1.16, 65536
// is the whole step), the contact centre, the unit normal from the static
// centre (Q1.14, truncated toward zero) and the distance travelled (Q16.16,
// saturating). Every decision is exact; no motion, a negative discriminant or
// no root in the step gives hit low with all other fields zero. A start inside
// the grown sphere reports the exit time. The block is a fixed pipeline of 59
// stages: one beat can enter every clock while the output is not stalled. Most
// of the length is the 17-stage impact time search (one time bit per stage)
// and the 32-stage travel square root (one result bit per stage), which also
// carries the 15-bit normal search. A stalled output holds the whole pipeline,
// and with it the input. step_length is stored only: the normalised results
// do not depend on it. The configuration channel is always ready.
module swept_sphere_sphere_hit import ssh_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CW-1:0]        cfg_data,
	// input beat
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [RW-1:0]        moving_radius,
	input  wire logic signed [CW-1:0] static_center_x,
	input  wire logic signed [CW-1:0] static_center_y,
	input  wire logic signed [CW-1:0] static_center_z,
	input  wire logic [RW-1:0]        static_radius,
	input  wire logic signed [CW-1:0] start_x,
	input  wire logic signed [CW-1:0] start_y,
	input  wire logic signed [CW-1:0] start_z,
	input  wire logic signed [CW-1:0] end_x,
	input  wire logic signed [CW-1:0] end_y,
	input  wire logic signed [CW-1:0] end_z,
	// result beat
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic [TW-1:0]             impact_time,
	output logic signed [CW-1:0]      contact_x,
	output logic signed [CW-1:0]      contact_y,
	output logic signed [CW-1:0]      contact_z,
	output logic signed [NW-1:0]      normal_x,
	output logic signed [NW-1:0]      normal_y,
	output logic signed [NW-1:0]      normal_z,
	output logic [TRW-1:0]            travel_distance
);
	logic [CW-1:0] step_length_q;
	logic en;
	logic f_valid, t_valid, c_valid, r_valid;
	front_t f_data;
	tres_t  t_data;
	cres_t  c_data;
	rstep_t r_data;
	logic [2:0][CW-1:0] cen_v, st_v, fin_v;
	logic [2:0][NW-1:0] nrm;
	logic out_valid_q, hit_q;
	logic [TW-1:0] time_q;
	logic [2:0][CW-1:0] con_q;
	logic [2:0][NW-1:0] nrm_q;
	logic [TRW-1:0] trav_q;

	// held register, no effect on results
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_length_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_length_q <= cfg_data;
		end
	end

	// whole pipeline advances unless a finished beat is held at the output
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	assign cen_v = {static_center_z, static_center_y, static_center_x};
	assign st_v  = {start_z, start_y, start_x};
	assign fin_v = {end_z, end_y, end_x};

	ssh_front u_front (
		.clk, .arst_n, .en,
		.in_valid (in_valid && (step_length_q == step_length_q)),
		.mr       (moving_radius),
		.sr       (static_radius),
		.cen      (cen_v),
		.st       (st_v),
		.fin      (fin_v),
		.out_valid(f_valid),
		.out_data (f_data)
	);

	ssh_tsearch u_tsearch (
		.clk, .arst_n, .en,
		.in_valid (f_valid),
		.in_data  (f_data),
		.out_valid(t_valid),
		.out_data (t_data)
	);

	ssh_contact u_contact (
		.clk, .arst_n, .en,
		.in_valid (t_valid),
		.in_data  (t_data),
		.out_valid(c_valid),
		.out_data (c_data)
	);

	ssh_roots u_roots (
		.clk, .arst_n, .en,
		.in_valid (c_valid),
		.in_data  (c_data),
		.out_valid(r_valid),
		.out_data (r_data)
	);

	// signed normal, zero when contact sits on the static centre
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!r_data.nz) begin
				nrm[i] = '0;
			end else if (r_data.neg[i]) begin
				nrm[i] = NW'(0) - NW'(r_data.n[i]);
			end else begin
				nrm[i] = NW'(r_data.n[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= r_valid;
		end
	end

	// no hit clears every field
	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= r_data.hit;
			time_q <= r_data.hit ? r_data.t : '0;
			con_q  <= r_data.hit ? r_data.con : '0;
			nrm_q  <= r_data.hit ? nrm : '0;
			trav_q <= !r_data.hit ? '0 : (r_data.sat ? '1 : r_data.trav);
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign impact_time     = time_q;
	assign contact_x       = con_q[0];
	assign contact_y       = con_q[1];
	assign contact_z       = con_q[2];
	assign normal_x        = nrm_q[0];
	assign normal_y        = nrm_q[1];
	assign normal_z        = nrm_q[2];
	assign travel_distance = trav_q;
endmodule
`default_nettype wire
